// ===== rtl/sia_pkg.sv =====
// Shared types, status codes and helper functions for the saturating integer ALU.
// Used by every module of the block; depends on nothing.
package sia_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int DATA_W     = 64;
    localparam int DIV_STEPS  = DATA_W;
    localparam int STG_IDX_W  = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
    localparam int S_TDATA_W  = 144;
    localparam int M_TDATA_W  = 72;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [3:0] KIND_BOOL = 4'd8;
    localparam logic [3:0] KIND_LAST_NUM = 4'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HIGH     = 3'd1;
    localparam logic [2:0] ST_LOW      = 3'd2;
    localparam logic [2:0] ST_DIVZ     = 3'd3;
    localparam logic [2:0] ST_BOOL     = 3'd4;
    localparam logic [2:0] ST_NONNUM   = 3'd5;
    localparam logic [2:0] ST_MISMATCH = 3'd6;

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        st;
        logic [1:0]        wcode;
        logic              sgn;
        logic              ln;
        logic              rn;
        logic [DATA_W-1:0] lm;
        logic [DATA_W-1:0] rm;
    } t_item;

    typedef struct packed {
        logic [1:0]        op;
        logic [2:0]        st;
        logic [1:0]        wcode;
        logic              sgn;
        logic              neg;
        logic              ln;
        logic              rn;
        logic [DATA_W-1:0] lm;
        logic [DATA_W-1:0] rm;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] pd;
    } t_stg;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wcode);
        logic [DATA_W-1:0] m;
        case (wcode)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic top_bit(input logic [DATA_W-1:0] v, input logic [1:0] wcode);
        logic b;
        case (wcode)
            2'd0:    b = v[7];
            2'd1:    b = v[15];
            2'd2:    b = v[31];
            default: b = v[63];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sia_front.sv =====
// Front end: takes input transfers, decodes kinds and errors, splits operands
// into sign and magnitude. Depends on sia_pkg.
module sia_front
    import sia_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_req_type,
    input  logic [3:0]           i_lhs_kind,
    input  logic [DATA_W-1:0]    i_lhs_bits,
    input  logic [3:0]           i_rhs_kind,
    input  logic [DATA_W-1:0]    i_rhs_bits,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_item                o_item
);

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic  [DATA_W-1:0] l_v;
    logic  [DATA_W-1:0] r_v;
    logic  [DATA_W-1:0] mask;
    logic  [1:0]        wcode;
    logic               sgn;
    logic               ln;
    logic               rn;
    logic               addsub;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        addsub = (i_req_type == OP_ADD) || (i_req_type == OP_SUB);
        wcode  = i_lhs_kind[2:1];
        sgn    = !i_lhs_kind[0];
        mask   = width_mask(wcode);
        l_v    = i_lhs_bits & mask;
        r_v    = i_rhs_bits & mask;
        ln     = sgn && top_bit(l_v, wcode);
        n_item.op    = i_req_type;
        n_item.wcode = wcode;
        n_item.sgn   = sgn;
        n_item.ln    = ln;
        n_item.lm    = ln ? ((~l_v) + 64'd1) & mask : l_v;
        if (addsub) begin
            rn = sgn && top_bit(r_v, wcode);
            n_item.rm = rn ? ((~r_v) + 64'd1) & mask : r_v;
            n_item.rn = rn ^ (i_req_type == OP_SUB);
        end else begin
            rn = i_rhs_bits[DATA_W-1];
            n_item.rm = rn ? (~i_rhs_bits) + 64'd1 : i_rhs_bits;
            n_item.rn = rn;
        end
        if (addsub && (i_lhs_kind != i_rhs_kind)) begin
            n_item.st = ST_MISMATCH;
        end else if (i_lhs_kind == KIND_BOOL) begin
            n_item.st = ST_BOOL;
        end else if (i_lhs_kind > KIND_LAST_NUM) begin
            n_item.st = ST_NONNUM;
        end else if ((32'd8 << wcode) > 32'(MAX_WIDTH)) begin
            n_item.st = ST_NONNUM;
        end else if ((i_req_type == OP_DIV) && (i_rhs_bits == '0)) begin
            n_item.st = ST_DIVZ;
        end else begin
            n_item.st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/sia_fifo.sv =====
// Short queue of decoded items between the front end and the execution pipe.
// Depends on sia_pkg.
module sia_fifo
    import sia_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_IDX_W-1:0] r_wp;
    logic [FIFO_IDX_W-1:0] r_rp;
    logic [FIFO_IDX_W:0]   r_cnt;
    logic                  push;
    logic                  pop;

    assign o_ready = r_cnt != (FIFO_IDX_W + 1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ===== rtl/sia_back.sv =====
// Execution pipe: add in the first stage, multiply over two stages, divide one
// quotient bit per stage, then clamp into the output register. Depends on sia_pkg.
module sia_back
    import sia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_item             i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_result,
    output logic [2:0]        o_status
);

    logic              en;
    logic              r_v   [DIV_STEPS];
    t_stg              r_stg [DIV_STEPS];
    t_stg              stg_in;
    logic              r_out_v;
    logic [DATA_W-1:0] r_res;
    logic [2:0]        r_st;
    logic [DATA_W-1:0] n_res;
    logic [2:0]        n_st;

    function automatic t_stg step(input t_stg s, input logic [STG_IDX_W-1:0] k);
        t_stg              o;
        logic [DATA_W:0]   t;
        logic [33:0]       mid;
        logic              q;
        o = s;
        t = '0;
        mid = '0;
        q = 1'b0;
        case (s.op)
            OP_ADD, OP_SUB: begin
                if (k == '0) begin
                    if (s.ln == s.rn) begin
                        t = {1'b0, s.lm} + {1'b0, s.rm};
                        o.lo  = t[DATA_W-1:0];
                        o.hi  = {63'd0, t[DATA_W]};
                        o.neg = s.rn;
                    end else if (s.lm >= s.rm) begin
                        o.lo  = s.lm - s.rm;
                        o.hi  = '0;
                        o.neg = s.ln;
                    end else begin
                        o.lo  = s.rm - s.lm;
                        o.hi  = '0;
                        o.neg = s.rn;
                    end
                end
            end
            OP_MUL: begin
                if (k == '0) begin
                    o.lo  = s.lm[31:0]  * s.rm[31:0];
                    o.pc  = s.lm[31:0]  * s.rm[63:32];
                    o.pd  = s.lm[63:32] * s.rm[31:0];
                    o.hi  = s.lm[63:32] * s.rm[63:32];
                    o.neg = s.ln ^ s.rn;
                end else if (k == STG_IDX_W'(1)) begin
                    mid  = {2'd0, s.lo[63:32]} + {2'd0, s.pc[31:0]} + {2'd0, s.pd[31:0]};
                    o.lo = {mid[31:0], s.lo[31:0]};
                    o.hi = s.hi + {32'd0, s.pc[63:32]} + {32'd0, s.pd[63:32]}
                         + {62'd0, mid[33:32]};
                end
            end
            default: begin
                if (k == '0) begin
                    o.neg = s.ln ^ s.rn;
                    o.hi  = '0;
                    o.lo  = s.lm;
                end
                t = {o.hi, o.lo[DATA_W-1]};
                if (t >= {1'b0, s.rm}) begin
                    t = t - {1'b0, s.rm};
                    q = 1'b1;
                end
                o.hi = t[DATA_W-1:0];
                o.lo = {o.lo[DATA_W-2:0], q};
            end
        endcase
        return o;
    endfunction

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_v;
    assign o_result = r_res;
    assign o_status = r_st;

    always_comb begin
        stg_in       = '0;
        stg_in.op    = i_item.op;
        stg_in.st    = i_item.st;
        stg_in.wcode = i_item.wcode;
        stg_in.sgn   = i_item.sgn;
        stg_in.ln    = i_item.ln;
        stg_in.rn    = i_item.rn;
        stg_in.lm    = i_item.lm;
        stg_in.rm    = i_item.rm;
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (en) begin
                if (g == 0) begin
                    r_v[g] <= i_valid;
                end else begin
                    r_v[g] <= r_v[g-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (g == 0) begin
                    r_stg[g] <= step(stg_in, STG_IDX_W'(g));
                end else begin
                    r_stg[g] <= step(r_stg[g-1], STG_IDX_W'(g));
                end
            end
        end
    end

    always_comb begin
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] maxpos;
        logic [DATA_W-1:0] minmag;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic              neg;
        t_stg              s;
        s      = r_stg[DIV_STEPS-1];
        m      = width_mask(s.wcode);
        maxpos = s.sgn ? (m >> 1) : m;
        minmag = s.sgn ? (m >> 1) + 64'd1 : '0;
        hi     = (s.op == OP_DIV) ? '0 : s.hi;
        lo     = s.lo;
        neg    = s.neg && ((hi != '0) || (lo != '0));
        if (s.st != ST_OK) begin
            n_res = '0;
            n_st  = s.st;
        end else if (!neg) begin
            if ((hi != '0) || (lo > maxpos)) begin
                n_res = maxpos;
                n_st  = ST_HIGH;
            end else begin
                n_res = lo;
                n_st  = ST_OK;
            end
        end else if ((hi != '0) || (lo > minmag)) begin
            n_res = minmag;
            n_st  = ST_LOW;
        end else begin
            n_res = ((~lo) + 64'd1) & m;
            n_st  = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_st  <= n_st;
        end
    end

endmodule

// ===== rtl/saturating_integer_alu.sv =====
// Saturating integer ALU top level: front end, item queue and execution pipe.
// Each item passes the front end, the queue (where it waits when stalled) and the pipe.
// Throughput is one item per cycle unless stalled; one quotient bit is retired per stage.
// The synchronous active-low reset clears all valid bits; payload is not reset.
// Depends on sia_pkg, sia_front, sia_fifo and sia_back.
module saturating_integer_alu
    import sia_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // req_type[1:0], lhs_kind[5:2], lhs_bits[69:6], rhs_kind[73:70], rhs_bits[137:74]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // result_bits[63:0], status[66:64]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic              fr_valid;
    logic              fr_ready;
    t_item             fr_item;
    logic              q_valid;
    logic              q_ready;
    t_item             q_item;
    logic [DATA_W-1:0] result;
    logic [2:0]        status;

    sia_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_req_type (i_s_axis_tdata[1:0]),
        .i_lhs_kind (i_s_axis_tdata[5:2]),
        .i_lhs_bits (i_s_axis_tdata[69:6]),
        .i_rhs_kind (i_s_axis_tdata[73:70]),
        .i_rhs_bits (i_s_axis_tdata[137:74]),
        .o_valid    (fr_valid),
        .i_ready    (fr_ready),
        .o_item     (fr_item)
    );

    sia_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_item  (fr_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    sia_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_item   (q_item),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result),
        .o_status (status)
    );

    assign o_m_axis_tdata = {5'd0, status, result};

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (status == ST_DIVZ || status == ST_BOOL ||
        status == ST_NONNUM || status == ST_MISMATCH) |-> result == '0)
        else $error("Error status with nonzero result.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> status <= ST_MISMATCH)
        else $error("Status code out of range.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !q_ready)
        else $error("Pipe advanced while the result was stalled.");
`endif

endmodule
